// File: rtl/sacl_pkg.sv
package sacl_pkg;

   localparam int WAYS     = 8;
   localparam int SETS     = 16384;
   localparam int TAG_BITS = 12;

   localparam int SET_BITS = $clog2(SETS);
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int AGE_BITS = $clog2(WAYS) + 1;

   localparam int TAG_ROW_BITS  = WAYS * TAG_BITS;
   localparam int META_ROW_BITS = WAYS * (2 + AGE_BITS);

   localparam int REQ_TYPE_BITS = 2;
   localparam int REQ_SET_BITS  = 14;
   localparam int REQ_TAG_BITS  = 12;
   localparam int REQ_RAW_BITS  = REQ_TYPE_BITS + REQ_SET_BITS + REQ_TAG_BITS;
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8;

   localparam int RSP_WAY_BITS  = 3;
   localparam int RSP_RAW_BITS  = 1 + RSP_WAY_BITS + 2 + 1;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_INVAL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      LINE_M = 2'd0,
      LINE_E = 2'd1,
      LINE_S = 2'd2,
      LINE_I = 2'd3
   } line_type;

   typedef enum logic [2:0] {
      FSM_CLEAR  = 3'b001,
      FSM_IDLE   = 3'b010,
      FSM_LOOKUP = 3'b100
   } fsm_type;

endpackage

// File: rtl/set_assoc_cache_lru_mesi.sv
// Tag store of a set-associative cache with age-counter LRU replacement and MESI line
// states. After reset the block runs a clearing pass over the line-state memory, one set per
// cycle, over all SETS sets (16384 at the default size), and accepts no request until it ends. Each
// transaction then has two steps: a synchronous read of the addressed set's tag and state rows,
// then a step to compare all ways, pick the victim, age the counters and write the rows back.
// The result is held in an output register, so a new request is taken while a result
// still waits; only the write-back step waits for the output register to be free.
module set_assoc_cache_lru_mesi (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: req_type[1:0], set_index[13:0], tag[11:0], zero fill.
   input  logic [sacl_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: hit, way[2:0], line_state[1:0], done_ok, zero fill.
   output logic [sacl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import sacl_pkg::*;

   logic [TAG_ROW_BITS-1:0]  tag_mem  [SETS];
   logic [META_ROW_BITS-1:0] meta_mem [SETS];

   fsm_type                  state_ff, state_in;
   logic [SET_BITS-1:0]      clear_idx_ff, clear_idx_in;
   op_type                   op_ff, op_in;
   logic [SET_BITS-1:0]      set_ff, set_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic [TAG_ROW_BITS-1:0]  tag_rd_ff;
   logic [META_ROW_BITS-1:0] meta_rd_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [SET_BITS-1:0]      rd_addr;
   logic                     req_take;
   logic                     finish;
   logic                     meta_we, tag_we;
   logic [SET_BITS-1:0]      meta_waddr;
   logic [META_ROW_BITS-1:0] meta_wdata, clear_row, upd_meta_row;
   logic [TAG_ROW_BITS-1:0]  upd_tag_row;
   logic                     upd_meta_we, upd_tag_we;

   logic [TAG_BITS-1:0]        way_tag [WAYS];
   line_type                   way_st  [WAYS];
   logic signed [AGE_BITS-1:0] way_age [WAYS];

   logic                     res_hit, res_ok;
   logic [WAY_BITS-1:0]      res_way;
   line_type                 res_state;

   assign req_take   = req_tvalid && req_tready;
   assign req_tready = (state_ff == FSM_IDLE);
   assign finish     = (state_ff == FSM_LOOKUP) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign op_in  = req_take ? op_type'(req_tdata[REQ_TYPE_BITS-1:0]) : op_ff;
   assign set_in = req_take ?
      SET_BITS'(req_tdata[REQ_TYPE_BITS +: REQ_SET_BITS]) : set_ff;
   assign tag_in = req_take ?
      TAG_BITS'(req_tdata[REQ_TYPE_BITS + REQ_SET_BITS +: REQ_TAG_BITS]) : tag_ff;
   assign rd_addr = req_take ? set_in : set_ff;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         clear_row[2*i +: 2] = LINE_I;
         clear_row[2*WAYS + i*AGE_BITS +: AGE_BITS] = {AGE_BITS{1'b1}};
         way_tag[i] = tag_rd_ff[i*TAG_BITS +: TAG_BITS];
         way_st[i]  = line_type'(meta_rd_ff[2*i +: 2]);
         way_age[i] = meta_rd_ff[2*WAYS + i*AGE_BITS +: AGE_BITS];
      end
   end

   always_comb begin
      logic                       hit_found, inv_found;
      logic [WAY_BITS-1:0]        hit_way, inv_way, lru_way, tgt;
      logic signed [AGE_BITS-1:0] inv_age, lru_age;
      line_type                   tgt_st;
      hit_found = 1'b0;
      inv_found = 1'b0;
      hit_way   = '0;
      inv_way   = '0;
      lru_way   = '0;
      inv_age   = '0;
      lru_age   = way_age[0];
      for (int i = 0; i < WAYS; i++) begin
         if (!hit_found && way_st[i] != LINE_I && way_tag[i] == tag_ff) begin
            hit_found = 1'b1;
            hit_way   = WAY_BITS'(i);
         end
         if (way_st[i] == LINE_I && (!inv_found || way_age[i] < inv_age)) begin
            inv_found = 1'b1;
            inv_way   = WAY_BITS'(i);
            inv_age   = way_age[i];
         end
         if (way_age[i] < lru_age) begin
            lru_way = WAY_BITS'(i);
            lru_age = way_age[i];
         end
      end
      tgt = hit_found ? hit_way : (inv_found ? inv_way : lru_way);

      upd_meta_row = meta_rd_ff;
      upd_tag_row  = tag_rd_ff;
      upd_meta_we  = 1'b0;
      upd_tag_we   = 1'b0;
      res_hit      = 1'b0;
      res_way      = '0;
      res_state    = LINE_I;
      res_ok       = 1'b0;
      tgt_st       = LINE_I;

      unique case (op_ff)
         OP_READ, OP_WRITE: begin
            if (op_ff == OP_WRITE) begin
               tgt_st = LINE_M;
            end else if (!hit_found) begin
               tgt_st = LINE_E;
            end else if (way_st[tgt] == LINE_E) begin
               tgt_st = LINE_S;
            end else begin
               tgt_st = way_st[tgt];
            end
            for (int i = 0; i < WAYS; i++) begin
               if (WAY_BITS'(i) == tgt) begin
                  upd_meta_row[2*i +: 2] = tgt_st;
                  upd_meta_row[2*WAYS + i*AGE_BITS +: AGE_BITS] = AGE_BITS'(WAYS - 1);
                  upd_tag_row[i*TAG_BITS +: TAG_BITS] = tag_ff;
               end else if (way_age[i] > 0) begin
                  upd_meta_row[2*WAYS + i*AGE_BITS +: AGE_BITS] = way_age[i] - AGE_BITS'(1);
               end
            end
            upd_meta_we = 1'b1;
            upd_tag_we  = !hit_found;
            res_hit     = hit_found;
            res_way     = tgt;
            res_state   = tgt_st;
            res_ok      = 1'b1;
         end
         OP_INVAL: begin
            if (hit_found) begin
               for (int i = 0; i < WAYS; i++) begin
                  if (WAY_BITS'(i) == hit_way) begin
                     upd_meta_row[2*i +: 2] = LINE_I;
                  end
               end
               upd_meta_we = 1'b1;
               res_hit     = 1'b1;
               res_way     = hit_way;
               res_ok      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (state_ff == FSM_CLEAR) begin
         meta_we    = 1'b1;
         meta_waddr = clear_idx_ff;
         meta_wdata = clear_row;
      end else begin
         meta_we    = finish && upd_meta_we;
         meta_waddr = set_ff;
         meta_wdata = upd_meta_row;
      end
      tag_we = finish && upd_tag_we;
   end

   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == SET_BITS'(SETS - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_take) begin
               state_in = FSM_LOOKUP;
            end
         end
         FSM_LOOKUP: begin
            if (finish) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_BITS'({res_ok, res_state, RSP_WAY_BITS'(res_way), res_hit});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[set_ff] <= upd_tag_row;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

endmodule

// File: sim/cache_check_pkg.sv
`timescale 1ns / 1ps
package cache_check_pkg;
   import sacl_pkg::*;

   typedef struct packed {
      logic           hit;
      logic [2:0]     way;
      line_type       st;
      logic           ok;
   } access_result;

   class mesi_scoreboard;
      logic [TAG_BITS-1:0] tag_mem[int];
      line_type            line_mem[int];
      int                  age_mem[int];
      access_result        expected_rsp[$];
      int                  mismatches;

      function new();
         mismatches = 0;
      endfunction

      function line_type line_at(int k);
         if (line_mem.exists(k)) return line_mem[k];
         return LINE_I;
      endfunction

      function int age_at(int k);
         if (age_mem.exists(k)) return age_mem[k];
         return -1;
      endfunction

      // Updates the set's tags, MESI states and age counters and queues the result.
      function void note_request(op_type op, logic [REQ_SET_BITS-1:0] s,
                                 logic [REQ_TAG_BITS-1:0] t);
         int base;
         int w;
         int best;
         bit found;
         bit hit;
         access_result want;
         base = int'(s) * WAYS;
         hit = 1'b0;
         w = 0;
         for (int i = 0; i < WAYS; i++) begin
            if (!hit && line_at(base + i) != LINE_I && tag_mem[base + i] == t) begin
               w = i;
               hit = 1'b1;
            end
         end
         want.hit = hit;
         if (op == OP_READ || op == OP_WRITE) begin
            if (!hit) begin
               found = 1'b0;
               best = 0;
               for (int i = 0; i < WAYS; i++) begin
                  if (line_at(base + i) == LINE_I &&
                      (!found || age_at(base + i) < age_at(base + best))) begin
                     best = i;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  for (int i = 1; i < WAYS; i++) begin
                     if (age_at(base + i) < age_at(base + best)) best = i;
                  end
               end
               w = best;
               tag_mem[base + w] = t;
               line_mem[base + w] = LINE_E;
            end
            for (int i = 0; i < WAYS; i++) begin
               if (i != w && age_at(base + i) > 0) age_mem[base + i] = age_at(base + i) - 1;
            end
            age_mem[base + w] = WAYS - 1;
            if (op == OP_WRITE) begin
               line_mem[base + w] = LINE_M;
            end else if (hit && line_at(base + w) == LINE_E) begin
               line_mem[base + w] = LINE_S;
            end
            want.st = line_at(base + w);
            want.ok = 1'b1;
         end else begin
            if (hit) line_mem[base + w] = LINE_I;
            else w = 0;
            want.st = LINE_I;
            want.ok = hit;
         end
         want.way = w[2:0];
         expected_rsp.push_back(want);
      endfunction

      function void check_response(logic [RSP_DATA_BITS-1:0] d);
         access_result got;
         access_result want;
         got.hit = d[0];
         got.way = d[3:1];
         got.st  = line_type'(d[5:4]);
         got.ok  = d[6];
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no request outstanding: hit=%0d way=%0d st=%0d ok=%0d",
                        $time, got.hit, got.way, got.st, got.ok);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.hit !== want.hit || got.way !== want.way || got.st !== want.st ||
             got.ok !== want.ok) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response mismatch: expected hit=%0d way=%0d st=%0d ok=%0d, got hit=%0d way=%0d st=%0d ok=%0d",
                        $time, want.hit, want.way, want.st, want.ok,
                        got.hit, got.way, got.st, got.ok);
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function int failures();
         return mismatches;
      endfunction
   endclass

endpackage

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import sacl_pkg::*;
   import cache_check_pkg::*;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   mesi_scoreboard           board = new();
   bit                       calm_req = 1'b0;
   bit                       calm_rsp = 1'b0;
   logic [REQ_SET_BITS-1:0]  hot_sets[4];
   logic [REQ_TAG_BITS-1:0]  hot_tags[12];

   set_assoc_cache_lru_mesi dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic access(op_type op, logic [REQ_SET_BITS-1:0] s, logic [REQ_TAG_BITS-1:0] t);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS - REQ_RAW_BITS){1'b0}}, t, s, op};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(op, s, t);
   endtask

   initial begin
      int pick;
      op_type op;
      hot_sets[0] = '0;
      hot_sets[1] = '1;
      hot_sets[2] = REQ_SET_BITS'($urandom);
      hot_sets[3] = REQ_SET_BITS'($urandom);
      hot_tags[0] = '0;
      hot_tags[1] = '1;
      for (int i = 2; i < 12; i++) hot_tags[i] = REQ_TAG_BITS'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A line in the top set walks through E, S, M and I; further accesses cover write misses and E to M.
      access(OP_READ,  '1, '1);
      access(OP_READ,  '1, '1);
      access(OP_READ,  '1, '1);
      access(OP_WRITE, '1, '1);
      access(OP_READ,  '1, '1);
      access(OP_INVAL, '1, '1);
      access(OP_INVAL, '1, '1);
      access(OP_WRITE, '1, '0);
      access(OP_READ,  14'd5, 12'd7);
      access(OP_WRITE, 14'd5, 12'd7);
      // Fill set zero, evict the oldest way, then refill a dropped way.
      for (int i = 0; i < 9; i++) access(OP_READ, '0, REQ_TAG_BITS'(i));
      access(OP_INVAL, '0, 12'd3);
      access(OP_READ,  '0, 12'h800);
      access(OP_READ,  '0, 12'd1);

      for (int n = 0; n < 1500; n++) begin
         if (n % 64 == 0) calm_req = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         op = (pick < 45) ? OP_READ : (pick < 80) ? OP_WRITE : OP_INVAL;
         if ($urandom_range(0, 4) != 0)
            access(op, hot_sets[$urandom_range(0, 3)], hot_tags[$urandom_range(0, 11)]);
         else
            access(op, REQ_SET_BITS'($urandom), REQ_TAG_BITS'($urandom));
      end
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.failures() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (taken % 64 == 0) calm_rsp = ($urandom_range(0, 3) == 0);
         stall = calm_rsp ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_response(rsp_tdata);
         taken++;
      end
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
